@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker of the identifier allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that the consequent holds whenever the antecedent holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/idal_pkg.sv @@
// Types and constants shared by the identifier allocator files.
package idal_pkg;

  localparam int unsigned MAX_IDS  = 1024;
  localparam int unsigned ID_W     = $clog2(MAX_IDS);
  localparam int unsigned CNT_W    = $clog2(MAX_IDS + 1);
  localparam int unsigned TAG_BITS = 32;

  localparam int unsigned OBJ_W    = 12;
  localparam int unsigned TAG_IN_W = 32;
  localparam int unsigned NEW_ID_W = 10;
  localparam int unsigned TAG_OUT_W = 32;
  localparam int unsigned LIVE_W   = 11;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_SET   = 2'd2,
    OP_GET   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    op_e                 op;
    logic [OBJ_W-1:0]    object_id;
    logic [TAG_IN_W-1:0] tag_in;
  } req_t;

  typedef struct packed {
    logic [NEW_ID_W-1:0]  new_id;
    logic [TAG_OUT_W-1:0] tag_out;
    status_e              status;
    logic [LIVE_W-1:0]    live_count;
  } rsp_t;

  typedef struct packed {
    logic            pop;
    logic            push;
    logic [ID_W-1:0] push_id;
  } q_ctrl_t;

endpackage

@@ rtl/idal_req_if.sv @@
// Request channel of the identifier allocator.
interface idal_req_if;
  logic          valid;
  logic          ready;
  idal_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/idal_rsp_if.sv @@
// Response channel of the identifier allocator.
interface idal_rsp_if;
  logic          valid;
  logic          ready;
  idal_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/idal_free_queue.sv @@
// Circular free list of identifiers with registered head read and write forwarding.
module idal_free_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  idal_pkg::q_ctrl_t            ctrl_i,
  output logic [idal_pkg::ID_W-1:0]    head_id_o
);

  localparam logic [idal_pkg::ID_W-1:0] LastSlot = idal_pkg::ID_W'(idal_pkg::MAX_IDS - 1);

  logic [idal_pkg::ID_W-1:0] mem [idal_pkg::MAX_IDS];
  logic [idal_pkg::ID_W-1:0] rd_q;
  logic [idal_pkg::ID_W-1:0] head_q, head_d;
  logic [idal_pkg::ID_W-1:0] tail_q, tail_d;
  logic                      wrapped_q, wrapped_d;
  logic                      fwd_q;
  logic [idal_pkg::ID_W-1:0] fwd_id_q;
  logic                      unwritten_q;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    wrapped_d = wrapped_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == LastSlot) ? '0 : head_q + 1'b1;
    end
    if (ctrl_i.push) begin
      tail_d = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
      if (tail_q == LastSlot) begin
        wrapped_d = 1'b1;
      end
    end
  end

  // Slots the tail has not yet reached hold no written identifier; the head output
  // then gives the slot index as their identifier.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= ctrl_i.push_id;
    end
    rd_q <= mem[head_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      wrapped_q   <= 1'b0;
      fwd_q       <= 1'b0;
      fwd_id_q    <= '0;
      unwritten_q <= 1'b1;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      wrapped_q   <= wrapped_d;
      fwd_q       <= ctrl_i.push && (tail_q == head_d);
      fwd_id_q    <= ctrl_i.push_id;
      unwritten_q <= !wrapped_d && (head_d >= tail_d);
    end
  end

  assign head_id_o = fwd_q ? fwd_id_q : (unwritten_q ? head_q : rd_q);

endmodule

@@ rtl/id_allocator_with_tag_table_unit.sv @@
// Top level of the identifier allocator with its per-identifier tag table.
// The block takes one operation per cycle while the response side does not stall: allocate,
// free, set tag or get tag. An accepted word is registered, then worked out against the free
// list and the tag table once the output register can take it, and its response is held in
// the output register until it is taken. Each memory has a single read and write port.
// After reset the tag table is cleared one entry per cycle, and no request is accepted
// until that pass has finished.
module id_allocator_with_tag_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  idal_req_if.sink    req_i,
  idal_rsp_if.source  rsp_o
);

  localparam logic [idal_pkg::ID_W-1:0]  LastIdx  = idal_pkg::ID_W'(idal_pkg::MAX_IDS - 1);
  localparam logic [idal_pkg::CNT_W-1:0] FullCnt  = idal_pkg::CNT_W'(idal_pkg::MAX_IDS);
  localparam logic [idal_pkg::OBJ_W-1:0] IdLimit  = idal_pkg::OBJ_W'(idal_pkg::MAX_IDS);

  logic [idal_pkg::TAG_BITS-1:0] tag_mem [idal_pkg::MAX_IDS];
  logic [idal_pkg::TAG_BITS-1:0] tag_rd_q;
  logic                          tag_fwd_q;
  logic [idal_pkg::TAG_BITS-1:0] tag_fwd_data_q;
  logic [idal_pkg::TAG_BITS-1:0] tag_val;

  logic                          clr_busy_q;
  logic [idal_pkg::ID_W-1:0]     clr_idx_q;

  logic                          s1_valid_q;
  idal_pkg::req_t                s1_req_q;
  logic                          s1_fire;
  logic                          in_accept;

  logic                          out_valid_q;
  idal_pkg::rsp_t                out_q;

  logic [idal_pkg::CNT_W-1:0]    count_q, count_d;

  logic                          tag_we;
  logic [idal_pkg::ID_W-1:0]     tag_waddr;
  logic [idal_pkg::TAG_BITS-1:0] tag_wdata;
  logic [idal_pkg::ID_W-1:0]     tag_raddr;

  logic [idal_pkg::ID_W-1:0]     s1_idx;
  logic                          range_err;
  logic                          do_pop;
  logic                          do_push;
  logic                          do_set;
  idal_pkg::rsp_t                rsp_d;
  idal_pkg::q_ctrl_t             q_ctrl;
  logic [idal_pkg::ID_W-1:0]     head_id;

  assign s1_fire   = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !clr_busy_q && (!s1_valid_q || s1_fire);
  assign in_accept = req_i.valid && req_i.ready;

  assign s1_idx    = s1_req_q.object_id[idal_pkg::ID_W-1:0];
  assign range_err = s1_req_q.object_id >= IdLimit;
  assign tag_val   = tag_fwd_q ? tag_fwd_data_q : tag_rd_q;

  always_comb begin
    do_pop  = 1'b0;
    do_push = 1'b0;
    do_set  = 1'b0;
    rsp_d   = '0;
    rsp_d.status = idal_pkg::ST_OK;
    unique case (s1_req_q.op)
      idal_pkg::OP_ALLOC: begin
        if (count_q == FullCnt) begin
          rsp_d.status = idal_pkg::ST_FULL;
        end else begin
          do_pop       = 1'b1;
          rsp_d.new_id = idal_pkg::NEW_ID_W'(head_id);
        end
      end
      idal_pkg::OP_FREE: begin
        if (range_err) begin
          rsp_d.status = idal_pkg::ST_RANGE;
        end else if (count_q == '0) begin
          rsp_d.status = idal_pkg::ST_EMPTY;
        end else begin
          do_push = 1'b1;
        end
      end
      idal_pkg::OP_SET: begin
        if (range_err) begin
          rsp_d.status = idal_pkg::ST_RANGE;
        end else begin
          do_set = 1'b1;
        end
      end
      idal_pkg::OP_GET: begin
        if (range_err) begin
          rsp_d.status = idal_pkg::ST_RANGE;
        end else begin
          rsp_d.tag_out = idal_pkg::TAG_OUT_W'(tag_val);
        end
      end
      default: begin
        rsp_d.status = idal_pkg::ST_OK;
      end
    endcase

    count_d = count_q;
    if (s1_fire && do_pop) begin
      count_d = count_q + 1'b1;
    end else if (s1_fire && do_push) begin
      count_d = count_q - 1'b1;
    end
    rsp_d.live_count = idal_pkg::LIVE_W'(count_d);
  end

  assign q_ctrl.pop     = s1_fire && do_pop;
  assign q_ctrl.push    = s1_fire && do_push;
  assign q_ctrl.push_id = s1_idx;

  idal_free_queue u_free_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (q_ctrl),
    .head_id_o (head_id)
  );

  // The clearing pass owns the write port until it has finished.
  always_comb begin
    if (clr_busy_q) begin
      tag_we    = 1'b1;
      tag_waddr = clr_idx_q;
      tag_wdata = '0;
    end else begin
      tag_we    = s1_fire && (do_push || do_set);
      tag_waddr = s1_idx;
      tag_wdata = do_set ? s1_req_q.tag_in[idal_pkg::TAG_BITS-1:0] : '0;
    end
  end

  assign tag_raddr = in_accept ? req_i.data.object_id[idal_pkg::ID_W-1:0] : s1_idx;

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    tag_rd_q <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_fwd_q      <= 1'b0;
      tag_fwd_data_q <= '0;
      clr_busy_q     <= 1'b1;
      clr_idx_q      <= '0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      count_q        <= '0;
    end else begin
      tag_fwd_q      <= tag_we && (tag_waddr == tag_raddr);
      tag_fwd_data_q <= tag_wdata;
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == LastIdx) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q <= req_i.data;
    end
    if (s1_fire) begin
      out_q <= rsp_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

@@ rtl/idal_checker.sv @@
// Port-level checks on the responses of the identifier allocator, bound to the top level.
`include "assert_macros.svh"

module idal_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input idal_pkg::rsp_t rsp_data_i
);

  localparam logic [idal_pkg::LIVE_W-1:0] FullCnt = idal_pkg::LIVE_W'(idal_pkg::MAX_IDS);

  logic err_rsp;
  logic no_payload;
  logic full_rsp;
  logic empty_rsp;
  logic stall;

  assign err_rsp    = rsp_valid_i && (rsp_data_i.status != idal_pkg::ST_OK);
  assign no_payload = (rsp_data_i.new_id == '0) && (rsp_data_i.tag_out == '0);
  assign full_rsp   = rsp_valid_i && (rsp_data_i.status == idal_pkg::ST_FULL);
  assign empty_rsp  = rsp_valid_i && (rsp_data_i.status == idal_pkg::ST_EMPTY);
  assign stall      = rsp_valid_i && !rsp_ready_i;

  `ASSERT_IMPLIES(a_err_no_payload, clk_i, rst_ni, err_rsp, no_payload, "Error word has a payload")
  `ASSERT_IMPLIES(a_full_count, clk_i, rst_ni, full_rsp, rsp_data_i.live_count == FullCnt, "Full below count")
  `ASSERT_IMPLIES(a_empty_count, clk_i, rst_ni, empty_rsp, rsp_data_i.live_count == '0, "Empty with live ids")
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, stall, rsp_valid_i && $stable(rsp_data_i), "Stalled word changed")

endmodule

bind id_allocator_with_tag_table_unit idal_checker u_idal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the identifier allocator with its per-identifier tag table.
`timescale 1ns / 100ps

module testbench;

  localparam logic [idal_pkg::ID_W-1:0]   LastIdx = idal_pkg::ID_W'(idal_pkg::MAX_IDS - 1);
  localparam logic [idal_pkg::LIVE_W-1:0] FullCnt = idal_pkg::LIVE_W'(idal_pkg::MAX_IDS);
  localparam logic [idal_pkg::OBJ_W-1:0]  IdLimit = idal_pkg::OBJ_W'(idal_pkg::MAX_IDS);
  localparam logic [idal_pkg::OBJ_W-1:0]  LastObj = idal_pkg::OBJ_W'(idal_pkg::MAX_IDS - 1);

  logic clk;
  logic rst_n;

  idal_req_if req_if();
  idal_rsp_if rsp_if();

  id_allocator_with_tag_table_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  logic [idal_pkg::ID_W-1:0]     free_ring [idal_pkg::MAX_IDS];
  logic [idal_pkg::ID_W-1:0]     ring_head;
  logic [idal_pkg::ID_W-1:0]     ring_tail;
  logic [idal_pkg::LIVE_W-1:0]   live_total;
  logic [idal_pkg::TAG_BITS-1:0] tag_store [idal_pkg::MAX_IDS];
  idal_pkg::rsp_t                expected_rsps [$];
  logic [idal_pkg::ID_W-1:0]     live_ids [$];
  int                            errors;
  bit                            src_idle;
  bit                            snk_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic idal_pkg::rsp_t predict_rsp(input idal_pkg::req_t w);
    idal_pkg::rsp_t            r;
    logic [idal_pkg::ID_W-1:0] slot;
    r = '0;
    r.status = idal_pkg::ST_OK;
    slot = w.object_id[idal_pkg::ID_W-1:0];
    if (w.op == idal_pkg::OP_ALLOC) begin
      if (live_total == FullCnt) begin
        r.status = idal_pkg::ST_FULL;
      end else begin
        r.new_id = idal_pkg::NEW_ID_W'(free_ring[ring_head]);
        ring_head = (ring_head == LastIdx) ? '0 : ring_head + 1'b1;
        live_total = live_total + 1'b1;
      end
    end else if (w.object_id >= IdLimit) begin
      r.status = idal_pkg::ST_RANGE;
    end else if (w.op == idal_pkg::OP_FREE) begin
      if (live_total == '0) begin
        r.status = idal_pkg::ST_EMPTY;
      end else begin
        tag_store[slot] = '0;
        free_ring[ring_tail] = slot;
        ring_tail = (ring_tail == LastIdx) ? '0 : ring_tail + 1'b1;
        live_total = live_total - 1'b1;
      end
    end else if (w.op == idal_pkg::OP_SET) begin
      tag_store[slot] = w.tag_in[idal_pkg::TAG_BITS-1:0];
    end else begin
      r.tag_out = idal_pkg::TAG_OUT_W'(tag_store[slot]);
    end
    r.live_count = live_total;
    return r;
  endfunction

  task automatic send_word(input idal_pkg::op_e op, input logic [idal_pkg::OBJ_W-1:0] id,
                           input logic [idal_pkg::TAG_IN_W-1:0] tag);
    idal_pkg::req_t w;
    idal_pkg::rsp_t r;
    int             idx [$];
    w.op = op;
    w.object_id = id;
    w.tag_in = tag;
    while (src_idle && $urandom_range(99) < 15) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= w;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    r = predict_rsp(w);
    expected_rsps.push_back(r);
    if (op == idal_pkg::OP_ALLOC && r.status == idal_pkg::ST_OK) live_ids.push_back(r.new_id);
    if (op == idal_pkg::OP_FREE && r.status == idal_pkg::ST_OK) begin
      idx = live_ids.find_first_index(x) with (x == id[idal_pkg::ID_W-1:0]);
      if (idx.size() != 0) live_ids.delete(idx[0]);
    end
  endtask

  task automatic wait_drain;
    req_if.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  function automatic logic [idal_pkg::OBJ_W-1:0] pick_id;
    int roll;
    roll = $urandom_range(99);
    if (roll < 70 && live_ids.size() != 0) begin
      return idal_pkg::OBJ_W'(live_ids[$urandom_range(live_ids.size() - 1)]);
    end
    if (roll < 90) return idal_pkg::OBJ_W'($urandom_range(idal_pkg::MAX_IDS - 1));
    return idal_pkg::OBJ_W'($urandom_range((1 << idal_pkg::OBJ_W) - 1));
  endfunction

  // Nothing is live yet, so frees are refused and every tag still reads as zero.
  task automatic test_empty_state;
    send_word(idal_pkg::OP_GET, '0, '0);
    send_word(idal_pkg::OP_GET, LastObj, '1);
    send_word(idal_pkg::OP_FREE, 12'd5, '0);
    send_word(idal_pkg::OP_FREE, '1, '1);
    send_word(idal_pkg::OP_SET, IdLimit, '1);
    send_word(idal_pkg::OP_GET, 12'hC00, '0);
  endtask

  task automatic test_tags;
    send_word(idal_pkg::OP_ALLOC, '1, '1);
    send_word(idal_pkg::OP_ALLOC, '0, '0);
    send_word(idal_pkg::OP_ALLOC, 12'h800, 32'h1234_5678);
    send_word(idal_pkg::OP_SET, 12'd0, '1);
    send_word(idal_pkg::OP_SET, 12'd1, '0);
    send_word(idal_pkg::OP_SET, LastObj, 32'hA5A5_5A5A);
    send_word(idal_pkg::OP_GET, 12'd0, '0);
    send_word(idal_pkg::OP_GET, 12'd1, '1);
    send_word(idal_pkg::OP_GET, LastObj, '0);
    wait_drain();
    send_word(idal_pkg::OP_FREE, 12'd0, '0);
    send_word(idal_pkg::OP_GET, 12'd0, '0);
    send_word(idal_pkg::OP_ALLOC, 12'h3FF, '0);
    send_word(idal_pkg::OP_FREE, 12'h400, '1);
    send_word(idal_pkg::OP_FREE, 12'd2, '0);
    send_word(idal_pkg::OP_SET, 12'd2, 32'h8000_0001);
    send_word(idal_pkg::OP_GET, 12'd2, '0);
  endtask

  // Allocates every identifier, asks for two more and then hands a share back in random order.
  task automatic test_fill;
    int n;
    while (live_total < FullCnt) begin
      send_word(idal_pkg::OP_ALLOC, idal_pkg::OBJ_W'($urandom_range(4095)), $urandom);
    end
    send_word(idal_pkg::OP_ALLOC, idal_pkg::OBJ_W'($urandom_range(4095)), $urandom);
    send_word(idal_pkg::OP_ALLOC, '0, '0);
    send_word(idal_pkg::OP_SET, idal_pkg::OBJ_W'($urandom_range(idal_pkg::MAX_IDS - 1)),
              $urandom);
    for (n = 0; n < 80; n++) begin
      send_word(idal_pkg::OP_FREE,
                idal_pkg::OBJ_W'(live_ids[$urandom_range(live_ids.size() - 1)]), $urandom);
    end
  endtask

  task automatic test_random;
    int n;
    int roll;
    int alloc_pct;
    for (n = 0; n < 200; n++) begin
      src_idle = (n >= 80);
      snk_idle = (n >= 80);
      alloc_pct = ((n / 100) % 2 == 0) ? 45 : 15;
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
        send_word(idal_pkg::OP_ALLOC, idal_pkg::OBJ_W'($urandom_range(4095)), $urandom);
      end else if (roll < 60) begin
        send_word(idal_pkg::OP_FREE, pick_id(), $urandom);
      end else if (roll < 80) begin
        send_word(idal_pkg::OP_SET, pick_id(), $urandom);
      end else begin
        send_word(idal_pkg::OP_GET, pick_id(), $urandom);
      end
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < idal_pkg::MAX_IDS; i++) begin
      free_ring[i] = idal_pkg::ID_W'(i);
      tag_store[i] = '0;
    end
    ring_head = '0;
    ring_tail = '0;
    live_total = '0;
    errors = 0;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_state();
    test_tags();
    test_fill();
    test_random();
    wait_drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    idal_pkg::rsp_t want;
    idal_pkg::rsp_t got;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (expected_rsps.size() == 0) begin
          $display("%0t: word with none expected: id %0d tag %h status %0d live %0d",
                   $time, got.new_id, got.tag_out, got.status, got.live_count);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.new_id !== want.new_id || got.tag_out !== want.tag_out ||
              got.status !== want.status || got.live_count !== want.live_count) begin
            $display("%0t: expected id %0d tag %h status %0d live %0d", $time,
                     want.new_id, want.tag_out, want.status, want.live_count);
            $display("%0t: actual   id %0d tag %h status %0d live %0d", $time,
                     got.new_id, got.tag_out, got.status, got.live_count);
            errors++;
          end
        end
      end
      rsp_if.ready <= rst_n && !(snk_idle && $urandom_range(99) < 15);
    end
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/idal_pkg.sv
rtl/idal_req_if.sv
rtl/idal_rsp_if.sv
rtl/idal_free_queue.sv
rtl/id_allocator_with_tag_table_unit.sv
rtl/idal_checker.sv
tb/testbench.sv
